// ----- rtl/fenwick_tree_engine_unit_assert.svh -----
// Assertion macros shared by the fenwick tree engine modules.
// Each use expects signals named clk and rst_n in the enclosing module.
`ifndef FENWICK_TREE_ENGINE_UNIT_ASSERT_SVH
`define FENWICK_TREE_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FTE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define FTE_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/fte_pkg.sv -----
// Shared types and constants of the fenwick tree engine.
// No dependencies; every other file but the assertion macro header imports this package.
package fte_pkg;

    // default sizing
    localparam int FTE_DEPTH      = 1024;
    localparam int FTE_VALUE_BITS = 48;

    // fixed field widths of the item channels
    localparam int OPC_W     = 3;
    localparam int IDX_W     = 10;
    localparam int AMT_W     = 48;
    localparam int VAL_OUT_W = 48;
    localparam int IDX_OUT_W = 11;
    localparam int CNT_OUT_W = 10;
    localparam int STAT_W    = 2;

    // item opcodes; code 7 is unused: it changes nothing but still gets a result item
    typedef enum logic [OPC_W-1:0] {
        OP_UPDATE  = 3'd0,
        OP_PREFIX  = 3'd1,
        OP_POINT   = 3'd2,
        OP_SRCH_LT = 3'd3,
        OP_SRCH_GE = 3'd4,
        OP_APPEND  = 3'd5,
        OP_CLEAR   = 3'd6
    } opcode_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        DP_IDLE,
        DP_LOAD,
        DP_LOAD_TGT,
        DP_RD_PTR,
        DP_RD_T,
        DP_UPD_WR,
        DP_ACC_ADD,
        DP_ACC_SUB,
        DP_PV_FIRST,
        DP_SR_LT,
        DP_SR_LE,
        DP_SR_SKIP,
        DP_AP_PTR,
        DP_AP_SAVE,
        DP_AP_DIFF,
        DP_AP_AMT,
        DP_AP_WR,
        DP_CLR,
        DP_RESULT
    } dp_op_t;

    // how the result item is formed
    typedef enum logic [2:0] {
        RES_NONE,
        RES_VALUE,
        RES_SEARCH,
        RES_IDX_ONE,
        RES_APPEND,
        RES_BAD_INDEX,
        RES_FULL
    } res_t;

    typedef struct packed {
        dp_op_t op;
        res_t   res;
    } dp_cmd_t;

    typedef struct packed {
        logic idx_ok;
        logic full;
        logic ptr_zero;
        logic upd_next_ok;
        logic clr_next_zero;
        logic ptr_gt_parent;
        logic clr_next_gt_parent;
        logic half_zero;
        logic t_le_count;
        logic amt_neg;
        logic amt_zero;
        logic out_free;
    } dp_stat_t;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_UPD_RD,
        S_UPD_WR,
        S_PS_RD,
        S_PS_ADD,
        S_PV_RD,
        S_PV_FIRST,
        S_PV_CHK,
        S_PV_RD2,
        S_PV_SUB,
        S_SR_CHK,
        S_SR_RD,
        S_SR_STEP,
        S_AP_CHK1,
        S_AP_RD1,
        S_AP_ADD1,
        S_AP_CHK2,
        S_AP_RD2,
        S_AP_ADD2,
        S_AP_AMT,
        S_AP_WR,
        S_RESULT
    } ctl_state_t;

endpackage

// ----- rtl/fte_if.sv -----
// Valid/ready item channels of the fenwick tree engine.
// Depends on fte_pkg for the field widths.
interface fte_cmd_if import fte_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OPC_W-1:0]        opcode;
    logic [IDX_W-1:0]        entry_index;
    logic signed [AMT_W-1:0] amount;

    modport source (output valid, opcode, entry_index, amount, input ready);
    modport sink   (input valid, opcode, entry_index, amount, output ready);
endinterface

interface fte_rsp_if import fte_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [VAL_OUT_W-1:0] value_out;
    logic [IDX_OUT_W-1:0]        index_out;
    logic [CNT_OUT_W-1:0]        count_out;
    logic [STAT_W-1:0]           status;

    modport source (output valid, value_out, index_out, count_out, status, input ready);
    modport sink   (input valid, value_out, index_out, count_out, status, output ready);
endinterface

// ----- rtl/fenwick_tree_engine_unit.sv -----
// Fenwick tree engine: one item at a time, one result item per item.
// Update and prefix walk the node chain; point value walks down to the parent; searches
// step once per tree level; append sums over two prefix chains; bad index, full table
// and clear go straight to the result.
// The next item is taken once the result is registered, even if the result waits.
// Reset clears the count and handshakes at once; node memory is not swept.
module fenwick_tree_engine_unit import fte_pkg::*;
#(
    parameter int DEPTH      = FTE_DEPTH,
    parameter int VALUE_BITS = FTE_VALUE_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    fte_cmd_if.sink   cmd,
    fte_rsp_if.source rsp
);

    dp_cmd_t  dcmd;
    dp_stat_t stat;

    // sequencer
    fte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_opcode (cmd.opcode),
        .in_ready  (cmd.ready),
        .stat      (stat),
        .dcmd      (dcmd)
    );

    // node store and arithmetic
    fte_dpath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_index (cmd.entry_index),
        .amount      (cmd.amount),
        .dcmd        (dcmd),
        .stat        (stat),
        .rsp         (rsp)
    );

endmodule

// ----- rtl/fte_ctrl.sv -----
// Sequencer of the fenwick tree engine: walks each operation as datapath commands.
// Depends on fte_pkg and the assertion macro header.
`include "fenwick_tree_engine_unit_assert.svh"

module fte_ctrl import fte_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [OPC_W-1:0] in_opcode,
    output logic             in_ready,
    input  dp_stat_t         stat,
    output dp_cmd_t          dcmd
);

    ctl_state_t       state_reg, state_next;
    logic [OPC_W-1:0] op_reg, op_next;
    res_t             res_reg, res_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            res_reg   <= RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            res_reg   <= res_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        res_next   = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                    op_next    = in_opcode;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESULT;
                res_next   = RES_NONE;
                unique case (opcode_t'(op_reg))
                    OP_UPDATE:
                    begin
                        if (!stat.idx_ok) res_next = RES_BAD_INDEX;
                        else              state_next = S_UPD_RD;
                    end
                    OP_PREFIX:
                    begin
                        if (!stat.idx_ok) res_next = RES_BAD_INDEX;
                        else              state_next = S_PS_RD;
                    end
                    OP_POINT:
                    begin
                        if (!stat.idx_ok) res_next = RES_BAD_INDEX;
                        else              state_next = S_PV_RD;
                    end
                    OP_SRCH_LT:
                    begin
                        // a negative target ends at index zero
                        if (!stat.amt_neg) state_next = S_SR_CHK;
                    end
                    OP_SRCH_GE:
                    begin
                        if (stat.amt_neg || stat.amt_zero) res_next = RES_IDX_ONE;
                        else                               state_next = S_SR_CHK;
                    end
                    OP_APPEND:
                    begin
                        if (stat.full) res_next = RES_FULL;
                        else           state_next = S_AP_CHK1;
                    end
                    OP_CLEAR:
                    begin
                        res_next = RES_NONE;
                    end
                    default:
                    begin
                        res_next = RES_NONE;
                    end
                endcase
            end
            S_UPD_RD:   state_next = S_UPD_WR;
            S_UPD_WR:   state_next = stat.upd_next_ok ? S_UPD_RD : S_RESULT;
            S_PS_RD:    state_next = S_PS_ADD;
            S_PS_ADD:
            begin
                if (stat.clr_next_zero)
                begin
                    state_next = S_RESULT;
                    res_next   = RES_VALUE;
                end
                else
                begin
                    state_next = S_PS_RD;
                end
            end
            S_PV_RD:    state_next = S_PV_FIRST;
            S_PV_FIRST: state_next = S_PV_CHK;
            S_PV_CHK:
            begin
                if (stat.ptr_gt_parent)
                begin
                    state_next = S_PV_RD2;
                end
                else
                begin
                    state_next = S_RESULT;
                    res_next   = RES_VALUE;
                end
            end
            S_PV_RD2:   state_next = S_PV_SUB;
            S_PV_SUB:
            begin
                if (stat.clr_next_gt_parent)
                begin
                    state_next = S_PV_RD2;
                end
                else
                begin
                    state_next = S_RESULT;
                    res_next   = RES_VALUE;
                end
            end
            S_SR_CHK:
            begin
                if (stat.half_zero)
                begin
                    state_next = S_RESULT;
                    res_next   = RES_SEARCH;
                end
                else if (stat.t_le_count)
                begin
                    state_next = S_SR_RD;
                end
            end
            S_SR_RD:    state_next = S_SR_STEP;
            S_SR_STEP:  state_next = S_SR_CHK;
            S_AP_CHK1:  state_next = stat.ptr_zero ? S_AP_CHK2 : S_AP_RD1;
            S_AP_RD1:   state_next = S_AP_ADD1;
            S_AP_ADD1:  state_next = S_AP_CHK1;
            S_AP_CHK2:  state_next = stat.ptr_zero ? S_AP_AMT : S_AP_RD2;
            S_AP_RD2:   state_next = S_AP_ADD2;
            S_AP_ADD2:  state_next = S_AP_CHK2;
            S_AP_AMT:   state_next = S_AP_WR;
            S_AP_WR:
            begin
                state_next = S_RESULT;
                res_next   = RES_APPEND;
            end
            S_RESULT:
            begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        in_ready  = 1'b0;
        dcmd.op   = DP_IDLE;
        dcmd.res  = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OP_SRCH_LT || in_opcode == OP_SRCH_GE)
                        dcmd.op = DP_LOAD_TGT;
                    else
                        dcmd.op = DP_LOAD;
                end
            end
            S_DISPATCH:
            begin
                if (op_reg == OP_APPEND && !stat.full)
                    dcmd.op = DP_AP_PTR;
                else if (op_reg == OP_CLEAR)
                    dcmd.op = DP_CLR;
            end
            S_UPD_RD:   dcmd.op = DP_RD_PTR;
            S_UPD_WR:   dcmd.op = DP_UPD_WR;
            S_PS_RD:    dcmd.op = DP_RD_PTR;
            S_PS_ADD:   dcmd.op = DP_ACC_ADD;
            S_PV_RD:    dcmd.op = DP_RD_PTR;
            S_PV_FIRST: dcmd.op = DP_PV_FIRST;
            S_PV_CHK:   dcmd.op = DP_IDLE;
            S_PV_RD2:   dcmd.op = DP_RD_PTR;
            S_PV_SUB:   dcmd.op = DP_ACC_SUB;
            S_SR_CHK:
            begin
                if (!stat.half_zero && !stat.t_le_count) dcmd.op = DP_SR_SKIP;
            end
            S_SR_RD:    dcmd.op = DP_RD_T;
            S_SR_STEP:  dcmd.op = (op_reg == OP_SRCH_LT) ? DP_SR_LT : DP_SR_LE;
            S_AP_CHK1:  dcmd.op = stat.ptr_zero ? DP_AP_SAVE : DP_IDLE;
            S_AP_RD1:   dcmd.op = DP_RD_PTR;
            S_AP_ADD1:  dcmd.op = DP_ACC_ADD;
            S_AP_CHK2:  dcmd.op = stat.ptr_zero ? DP_AP_DIFF : DP_IDLE;
            S_AP_RD2:   dcmd.op = DP_RD_PTR;
            S_AP_ADD2:  dcmd.op = DP_ACC_ADD;
            S_AP_AMT:   dcmd.op = DP_AP_AMT;
            S_AP_WR:    dcmd.op = DP_AP_WR;
            S_RESULT:   dcmd.op = stat.out_free ? DP_RESULT : DP_IDLE;
            default:    dcmd.op = DP_IDLE;
        endcase
    end

    // checks
    `FTE_ASSERT_NXT(a_accept_dispatch, in_valid && in_ready, state_reg == S_DISPATCH, "item accepted but no dispatch")
    `FTE_ASSERT_IMP(a_result_slot_free, dcmd.op == DP_RESULT, stat.out_free, "result issued over an untaken item")

endmodule

// ----- rtl/fte_dpath.sv -----
// Datapath of the fenwick tree engine: node memory, accumulator, walk pointers
// and the result register. Depends on fte_pkg and the assertion macro header.
`include "fenwick_tree_engine_unit_assert.svh"

module fte_dpath import fte_pkg::*;
#(
    parameter int DEPTH      = FTE_DEPTH,
    parameter int VALUE_BITS = FTE_VALUE_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [IDX_W-1:0]        entry_index,
    input  logic signed [AMT_W-1:0] amount,
    input  dp_cmd_t                 dcmd,
    output dp_stat_t                stat,
    fte_rsp_if.source               rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int PW = IW + 1;
    localparam logic [IW-1:0] TopHalf = IW'(1) << (IW - 1);
    localparam logic [IW-1:0] FullCnt = IW'(DEPTH - 1);

    // node store, no reset: entries above the count are never read
    logic signed [VALUE_BITS-1:0] mem [DEPTH];

    logic signed [VALUE_BITS-1:0] rd_reg;
    logic signed [VALUE_BITS-1:0] acc_reg, acc_next;
    logic signed [VALUE_BITS-1:0] sav_reg, sav_next;
    logic signed [VALUE_BITS-1:0] amt_reg, amt_next;
    logic [PW-1:0]                ptr_reg, ptr_next;
    logic [IW-1:0]                parent_reg, parent_next;
    logic [IW-1:0]                base_reg, base_next;
    logic [IW-1:0]                half_reg, half_next;
    logic [IW-1:0]                count_reg, count_next;
    logic                         ovf_reg, ovf_next;
    logic                         idx_ok_reg, idx_ok_next;
    logic                         out_valid_reg, out_valid_next;
    logic signed [VAL_OUT_W-1:0]  value_reg, value_next;
    logic [IDX_OUT_W-1:0]         index_reg, index_next;
    logic [CNT_OUT_W-1:0]         count_out_reg, count_out_next;
    status_t                      status_reg, status_next;

    // shared adder
    logic signed [VALUE_BITS-1:0] alu_a, alu_b, alu_sum;
    logic                         alu_sub, alu_ovf;

    // walk arithmetic
    logic [PW-1:0] t_idx;
    logic [PW-1:0] upd_next_ptr;
    logic [PW-1:0] clr_next_ptr;
    logic          go_lt, go_le;

    // memory ports
    logic                         mem_re, mem_we;
    logic [IW-1:0]                rd_addr, wr_addr;
    logic signed [VALUE_BITS-1:0] wr_data;

    // operand selection for the adder
    always_comb
    begin
        alu_a   = acc_reg;
        alu_b   = rd_reg;
        alu_sub = 1'b0;
        unique case (dcmd.op)
            DP_ACC_SUB, DP_SR_LT, DP_SR_LE:
            begin
                alu_sub = 1'b1;
            end
            DP_UPD_WR:
            begin
                alu_a = rd_reg;
                alu_b = amt_reg;
            end
            DP_AP_DIFF:
            begin
                alu_a   = sav_reg;
                alu_b   = acc_reg;
                alu_sub = 1'b1;
            end
            DP_AP_AMT:
            begin
                alu_b = amt_reg;
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // wrapping add or subtract with signed overflow flag
    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_ovf = alu_sub
        ? ((alu_a[VALUE_BITS-1] != alu_b[VALUE_BITS-1]) &&
           (alu_sum[VALUE_BITS-1] != alu_a[VALUE_BITS-1]))
        : ((alu_a[VALUE_BITS-1] == alu_b[VALUE_BITS-1]) &&
           (alu_sum[VALUE_BITS-1] != alu_a[VALUE_BITS-1]));

    // pointer steps: up by lowest set bit, down by clearing it
    assign t_idx        = PW'(base_reg) + PW'(half_reg);
    assign upd_next_ptr = ptr_reg + (ptr_reg & (PW'(0) - ptr_reg));
    assign clr_next_ptr = ptr_reg & (ptr_reg - PW'(1));

    // search compares against the remaining target
    assign go_lt = rd_reg < acc_reg;
    assign go_le = !(acc_reg < rd_reg);

    // status to the controller
    always_comb
    begin
        stat.idx_ok             = idx_ok_reg;
        stat.full               = (count_reg == FullCnt);
        stat.ptr_zero           = (ptr_reg == '0);
        stat.upd_next_ok        = (upd_next_ptr <= PW'(count_reg));
        stat.clr_next_zero      = (clr_next_ptr == '0);
        stat.ptr_gt_parent      = (ptr_reg > PW'(parent_reg));
        stat.clr_next_gt_parent = (clr_next_ptr > PW'(parent_reg));
        stat.half_zero          = (half_reg == '0);
        stat.t_le_count         = (t_idx <= PW'(count_reg));
        stat.amt_neg            = amt_reg[VALUE_BITS-1];
        stat.amt_zero           = (amt_reg == '0);
        stat.out_free           = !out_valid_reg || rsp.ready;
    end

    // register updates per command
    always_comb
    begin
        acc_next       = acc_reg;
        sav_next       = sav_reg;
        amt_next       = amt_reg;
        ptr_next       = ptr_reg;
        parent_next    = parent_reg;
        base_next      = base_reg;
        half_next      = half_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_ok_next    = idx_ok_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        count_out_next = count_out_reg;
        status_next    = status_reg;
        out_valid_next = (out_valid_reg && !rsp.ready);
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        rd_addr        = ptr_reg[IW-1:0];
        wr_addr        = ptr_reg[IW-1:0];
        wr_data        = alu_sum;
        unique case (dcmd.op)
            DP_LOAD, DP_LOAD_TGT:
            begin
                amt_next    = VALUE_BITS'(amount);
                acc_next    = (dcmd.op == DP_LOAD_TGT) ? VALUE_BITS'(amount) : '0;
                ovf_next    = 1'b0;
                ptr_next    = PW'(entry_index);
                parent_next = IW'(entry_index) & (IW'(entry_index) - IW'(1));
                base_next   = '0;
                half_next   = TopHalf;
                idx_ok_next = (entry_index != '0) &&
                              (32'(entry_index) <= 32'(count_reg));
            end
            DP_RD_PTR:
            begin
                mem_re = 1'b1;
            end
            DP_RD_T:
            begin
                mem_re  = 1'b1;
                rd_addr = t_idx[IW-1:0];
            end
            DP_UPD_WR:
            begin
                mem_we   = 1'b1;
                ovf_next = ovf_reg | alu_ovf;
                ptr_next = upd_next_ptr;
            end
            DP_ACC_ADD, DP_ACC_SUB:
            begin
                acc_next = alu_sum;
                ovf_next = ovf_reg | alu_ovf;
                ptr_next = clr_next_ptr;
            end
            DP_PV_FIRST:
            begin
                acc_next = rd_reg;
                ptr_next = ptr_reg - PW'(1);
            end
            DP_SR_LT, DP_SR_LE:
            begin
                if ((dcmd.op == DP_SR_LT) ? go_lt : go_le)
                begin
                    base_next = t_idx[IW-1:0];
                    acc_next  = alu_sum;
                    ovf_next  = ovf_reg | alu_ovf;
                end
                half_next = half_reg >> 1;
            end
            DP_SR_SKIP:
            begin
                half_next = half_reg >> 1;
            end
            DP_AP_PTR:
            begin
                ptr_next    = PW'(count_reg);
                parent_next = (count_reg + IW'(1)) & count_reg;
            end
            DP_AP_SAVE:
            begin
                sav_next = acc_reg;
                acc_next = '0;
                ptr_next = PW'(parent_reg);
            end
            DP_AP_DIFF, DP_AP_AMT:
            begin
                acc_next = alu_sum;
                ovf_next = ovf_reg | alu_ovf;
            end
            DP_AP_WR:
            begin
                mem_we     = 1'b1;
                wr_addr    = count_reg + IW'(1);
                wr_data    = acc_reg;
                count_next = count_reg + IW'(1);
            end
            DP_CLR:
            begin
                count_next = '0;
            end
            DP_RESULT:
            begin
                out_valid_next = 1'b1;
                count_out_next = CNT_OUT_W'(32'(count_reg));
                value_next     = '0;
                index_next     = '0;
                status_next    = ovf_reg ? ST_OVERFLOW : ST_OK;
                unique case (dcmd.res)
                    RES_VALUE:     value_next  = VAL_OUT_W'(acc_reg);
                    RES_SEARCH:    index_next  = IDX_OUT_W'(PW'(base_reg) + PW'(1));
                    RES_IDX_ONE:   index_next  = IDX_OUT_W'(1);
                    RES_APPEND:    index_next  = IDX_OUT_W'(32'(count_reg));
                    RES_BAD_INDEX: status_next = ST_BAD_INDEX;
                    RES_FULL:      status_next = ST_FULL;
                    default:       index_next  = '0;
                endcase
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    // node memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        if (mem_re)
            rd_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            half_reg      <= '0;
            ptr_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_ok_reg    <= idx_ok_next;
            out_valid_reg <= out_valid_next;
            half_reg      <= half_next;
            ptr_reg       <= ptr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sav_reg       <= sav_next;
        amt_reg       <= amt_next;
        parent_reg    <= parent_next;
        base_reg      <= base_next;
        value_reg     <= value_next;
        index_reg     <= index_next;
        count_out_reg <= count_out_next;
        status_reg    <= status_next;
    end

    // result channel
    assign rsp.valid     = out_valid_reg;
    assign rsp.value_out = value_reg;
    assign rsp.index_out = index_reg;
    assign rsp.count_out = count_out_reg;
    assign rsp.status    = status_reg;

    // checks
    `FTE_ASSERT_IMP(a_upd_in_range, dcmd.op == DP_UPD_WR, ptr_reg != '0 && ptr_reg <= PW'(count_reg), "update writes outside the filled nodes")
    `FTE_ASSERT_IMP(a_append_not_full, dcmd.op == DP_AP_WR, count_reg != FullCnt, "append past the last node")
    `FTE_ASSERT_NXT(a_result_shown, dcmd.op == DP_RESULT, out_valid_reg, "result not presented")

endmodule

// ----- tb/fenwick_tree_engine_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of fenwick_tree_engine_unit: directed table, then random traffic.
// Depends on fte_pkg, the fte_cmd_if / fte_rsp_if channels and the engine RTL.
module fenwick_tree_engine_unit_test;
    import fte_pkg::*;

    localparam int SLOTS     = FTE_DEPTH;
    localparam int TOP_HALF  = 512;
    localparam int IDLE_MAX  = 2000;
    localparam int DRAIN_CYC = 100;

    localparam logic [OPC_W-1:0] OPC_NOP  = 3'd7;
    localparam logic [AMT_W-1:0] Q_ONE    = 48'h100_0000;
    localparam logic [AMT_W-1:0] AMT_MAX  = 48'h7FFF_FFFF_FFFF;
    localparam logic [AMT_W-1:0] AMT_MIN  = 48'h8000_0000_0000;
    localparam logic [AMT_W-1:0] AMT_NEG1 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [VAL_OUT_W-1:0] value;
        logic [IDX_OUT_W-1:0] index;
        logic [CNT_OUT_W-1:0] count;
        logic [STAT_W-1:0]    status;
    } result_t;

    typedef struct packed {
        logic [OPC_W-1:0]     op;
        logic [IDX_W-1:0]     idx;
        logic [AMT_W-1:0]     amt;
        bit                   typed;
        logic [VAL_OUT_W-1:0] e_val;
        logic [IDX_OUT_W-1:0] e_idx;
        logic [CNT_OUT_W-1:0] e_cnt;
        status_t              e_st;
    } plan_row_t;

    logic clk;
    logic rst_n;

    fte_cmd_if cmd_ch ();
    fte_rsp_if rsp_ch ();

    fenwick_tree_engine_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // tree state of the predictor
    logic [AMT_W-1:0] node_sum [SLOTS];
    int               entry_cnt;
    bit               arith_ovf;

    result_t pending_results [$];
    result_t seen_want;
    int      err_count;
    int      items_sent;
    int      idle_cycles;
    bit      send_calm;
    bit      recv_calm;

    // directed stimulus; typed rows carry their own expected result
    plan_row_t dir_plan [25] = '{
        '{OP_PREFIX,  10'd0,    48'd0,         1'b1, 48'd0, 11'd0, 10'd0, ST_BAD_INDEX},
        '{OP_UPDATE,  10'd0,    AMT_MAX,       1'b1, 48'd0, 11'd0, 10'd0, ST_BAD_INDEX},
        '{OP_SRCH_LT, 10'd0,    AMT_NEG1,      1'b1, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_SRCH_GE, 10'd0,    48'd0,         1'b1, 48'd0, 11'd1, 10'd0, ST_OK},
        '{OP_SRCH_GE, 10'd1023, Q_ONE,         1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_APPEND,  10'd0,    AMT_MAX,       1'b1, 48'd0, 11'd1, 10'd1, ST_OK},
        '{OP_APPEND,  10'd0,    48'd1,         1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_PREFIX,  10'd2,    48'd0,         1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_POINT,   10'd2,    48'd0,         1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_POINT,   10'd3,    48'd0,         1'b1, 48'd0, 11'd0, 10'd2, ST_BAD_INDEX},
        '{OP_UPDATE,  10'd1,    AMT_MIN,       1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_APPEND,  10'd0,    AMT_MIN,       1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_SRCH_LT, 10'd0,    48'd0,         1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_SRCH_LT, 10'd0,    AMT_MAX,       1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_SRCH_GE, 10'd0,    AMT_MIN,       1'b1, 48'd0, 11'd1, 10'd3, ST_OK},
        '{OPC_NOP,    10'd1023, AMT_NEG1,      1'b1, 48'd0, 11'd0, 10'd3, ST_OK},
        '{OP_PREFIX,  10'd1023, 48'd0,         1'b1, 48'd0, 11'd0, 10'd3, ST_BAD_INDEX},
        '{OP_UPDATE,  10'd3,    48'h500_0000,  1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_PREFIX,  10'd3,    48'd0,         1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_CLEAR,   10'd1023, AMT_NEG1,      1'b1, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_POINT,   10'd1,    48'd0,         1'b1, 48'd0, 11'd0, 10'd0, ST_BAD_INDEX},
        '{OP_APPEND,  10'd0,    48'h500_0000,  1'b1, 48'd0, 11'd1, 10'd1, ST_OK},
        '{OP_APPEND,  10'd0,    48'h300_0000,  1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_SRCH_GE, 10'd0,    48'h500_0000,  1'b0, 48'd0, 11'd0, 10'd0, ST_OK},
        '{OP_SRCH_LT, 10'd0,    48'h500_0000,  1'b0, 48'd0, 11'd0, 10'd0, ST_OK}
    };

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // wrapping add and subtract, flagging signed overflow
    function automatic logic [AMT_W-1:0] wrap_add(input logic [AMT_W-1:0] a, b);
        logic [AMT_W-1:0] s;
        s = a + b;
        if (a[AMT_W-1] == b[AMT_W-1] && s[AMT_W-1] != a[AMT_W-1])
            arith_ovf = 1'b1;
        return s;
    endfunction

    function automatic logic [AMT_W-1:0] wrap_sub(input logic [AMT_W-1:0] a, b);
        logic [AMT_W-1:0] d;
        d = a - b;
        if (a[AMT_W-1] != b[AMT_W-1] && d[AMT_W-1] != a[AMT_W-1])
            arith_ovf = 1'b1;
        return d;
    endfunction

    function automatic logic [AMT_W-1:0] prefix_sum(input int ix);
        logic [AMT_W-1:0] s;
        s = '0;
        while (ix > 0 && ix < SLOTS)
        begin
            s  = wrap_add(s, node_sum[ix]);
            ix = ix & (ix - 1);
        end
        return s;
    endfunction

    // binary descent over the tree; strict uses less-than, else at-most
    function automatic logic [IDX_OUT_W-1:0] weighted_search(input logic [AMT_W-1:0] target,
                                                             input bit strict);
        int base;
        int h;
        int t;
        bit go;
        base = 0;
        if (strict)
        begin
            if ($signed(target) < 0)
                return '0;
        end
        else if (!($signed(target) > 0))
            return 11'd1;
        for (h = TOP_HALF; h > 0; h = h >> 1)
        begin
            t = base + h;
            if (t <= entry_cnt && t < SLOTS)
            begin
                go = strict ? ($signed(node_sum[t]) < $signed(target))
                            : !($signed(target) < $signed(node_sum[t]));
                if (go)
                begin
                    base   = t;
                    target = wrap_sub(target, node_sum[t]);
                end
            end
        end
        return IDX_OUT_W'(base + 1);
    endfunction

    // expected result of one item; updates the predictor's tree
    function automatic void predict_result(input logic [OPC_W-1:0] op,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [AMT_W-1:0] amt,
                                           output result_t res);
        int      i;
        int      k;
        int      n;
        int      parent;
        bit      idx_ok;
        status_t st;
        i         = idx;
        res       = '0;
        st        = ST_OK;
        arith_ovf = 1'b0;
        idx_ok    = i >= 1 && i <= entry_cnt && i < SLOTS;
        case (op)
            OP_UPDATE:
                if (!idx_ok)
                    st = ST_BAD_INDEX;
                else
                    for (k = i; k <= entry_cnt && k < SLOTS; k += k & (-k))
                        node_sum[k] = wrap_add(node_sum[k], amt);
            OP_PREFIX:
                if (!idx_ok)
                    st = ST_BAD_INDEX;
                else
                    res.value = prefix_sum(i);
            OP_POINT:
                if (!idx_ok)
                    st = ST_BAD_INDEX;
                else
                begin
                    res.value = node_sum[i];
                    parent    = i & (i - 1);
                    for (k = i - 1; k > parent; k = k & (k - 1))
                        res.value = wrap_sub(res.value, node_sum[k]);
                end
            OP_SRCH_LT:
                res.index = weighted_search(amt, 1'b1);
            OP_SRCH_GE:
                res.index = weighted_search(amt, 1'b0);
            OP_APPEND:
                if (entry_cnt >= SLOTS - 1)
                    st = ST_FULL;
                else
                begin
                    n = entry_cnt + 1;
                    node_sum[n] = wrap_add(wrap_sub(prefix_sum(entry_cnt),
                                                    prefix_sum(n & (n - 1))), amt);
                    entry_cnt = n;
                    res.index = IDX_OUT_W'(n);
                end
            OP_CLEAR:
            begin
                foreach (node_sum[j])
                    node_sum[j] = '0;
                entry_cnt = 0;
            end
            default: ;
        endcase
        if (st == ST_OK && arith_ovf)
            st = ST_OVERFLOW;
        res.count  = CNT_OUT_W'(entry_cnt);
        res.status = st;
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [AMT_W-1:0] pick_amount();
        int               r;
        int               s;
        logic signed [AMT_W-1:0] t;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            s = int'($urandom_range(0, (1 << 29) - 1)) - (1 << 28);
            t = s;
            return t;
        end
        if (r < 60)
            return AMT_W'($urandom_range(0, 1 << 26));
        if (r < 85)
            return AMT_W'({$urandom, $urandom});
        if (r < 95)
            case ($urandom_range(0, 4))
                0: return AMT_MAX;
                1: return AMT_MIN;
                2: return '0;
                3: return AMT_NEG1;
                default: return 48'd1;
            endcase
        if (r < 98)
            return AMT_MAX - AMT_W'($urandom_range(0, 1000));
        return AMT_MIN + AMT_W'($urandom_range(0, 1000));
    endfunction

    // search target often near a real prefix sum
    function automatic logic [AMT_W-1:0] pick_target();
        int               r;
        int               s;
        logic signed [AMT_W-1:0] t;
        r = $urandom_range(0, 99);
        if (r < 45 && entry_cnt > 0)
        begin
            s = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 4095)) - 2048
                                          : int'($urandom_range(0, 2)) - 1;
            t = s;
            return prefix_sum($urandom_range(1, entry_cnt)) + t;
        end
        if (r < 55)
            return AMT_NEG1 - AMT_W'($urandom_range(0, 1 << 20));
        if (r < 65)
            return '0;
        if (r < 75)
            return prefix_sum(entry_cnt) + 48'd1;
        return pick_amount();
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && entry_cnt > 0)
            return IDX_W'($urandom_range(1, entry_cnt));
        if (r < 78)
            return IDX_W'(entry_cnt);
        if (r < 83)
            return IDX_W'(entry_cnt + 1);
        if (r < 86)
            return '0;
        return IDX_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [OPC_W-1:0] pick_mixed_op();
        int r;
        r = $urandom_range(0, 99);
        if (entry_cnt > 40 && r < 8)
            return OP_CLEAR;
        if (r < 30 || r >= 92)
            return OP_APPEND;
        if (r < 45)
            return OP_UPDATE;
        if (r < 58)
            return OP_PREFIX;
        if (r < 68)
            return OP_POINT;
        if (r < 78)
            return OP_SRCH_LT;
        if (r < 88)
            return OP_SRCH_GE;
        if (r < 90)
            return OP_CLEAR;
        return OPC_NOP;
    endfunction

    // drive one item, wait for acceptance, queue its expected result
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [AMT_W-1:0] amt, input bit typed,
                             input result_t given);
        result_t r;
        int      gap;
        gap = send_calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.entry_index <= idx;
        cmd_ch.amount      <= amt;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        predict_result(op, idx, amt, r);
        pending_results.push_back(typed ? given : r);
        items_sent++;
        if (items_sent % 64 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
    endtask

    task automatic send_op(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [AMT_W-1:0] amt);
        send_item(op, idx, amt, 1'b0, '0);
    endtask

    // queries and argument pick that suit the operation
    task automatic send_random(input logic [OPC_W-1:0] op);
        if (op == OP_SRCH_LT || op == OP_SRCH_GE)
            send_op(op, IDX_W'($urandom_range(0, 1023)), pick_target());
        else
            send_op(op, pick_index(), pick_amount());
    endtask

    // small tables with all operations mixed
    task automatic run_mixed(input int n_items);
        repeat (n_items)
            send_random(pick_mixed_op());
    endtask

    // grow the table to its full size, then probe the edges
    task automatic fill_to_full();
        int               r;
        logic [AMT_W-1:0] total;
        send_op(OP_CLEAR, '0, '0);
        while (entry_cnt < SLOTS - 1)
        begin
            r = $urandom_range(0, 99);
            if (r < 95)
                send_op(OP_APPEND, IDX_W'($urandom), AMT_W'($urandom_range(0, 1 << 26)));
            else if (r < 96)
                send_random(OP_UPDATE);
            else if (r < 97)
                send_random(OP_PREFIX);
            else if (r < 98)
                send_random(OP_POINT);
            else if (r < 99)
                send_random(OP_SRCH_LT);
            else
                send_random(OP_SRCH_GE);
        end
        repeat (3)
            send_op(OP_APPEND, '0, pick_amount());
        send_op(OP_PREFIX, 10'd1023, '0);
        send_op(OP_POINT, 10'd1023, '0);
        send_op(OP_POINT, 10'd512, '0);
        send_op(OP_POINT, 10'd1, '0);
        total = prefix_sum(entry_cnt);
        send_op(OP_SRCH_GE, '0, total + 48'd1);
        send_op(OP_SRCH_LT, '0, total + 48'd1);
        send_op(OP_SRCH_GE, '0, prefix_sum(600));
        send_op(OP_SRCH_LT, '0, prefix_sum(600));
        send_op(OP_UPDATE, 10'd1023, pick_amount());
        send_op(OP_UPDATE, 10'd1, AMT_MAX);
        send_op(OP_PREFIX, 10'd1023, '0);
        send_op(OP_SRCH_GE, '0, AMT_MAX);
        send_op(OP_UPDATE, 10'd0, Q_ONE);
        send_op(OPC_NOP, 10'd512, AMT_MIN);
        send_op(OP_CLEAR, '0, '0);
    endtask

    // response back-pressure
    initial
    begin
        int stall;
        int cyc;
        stall        = 0;
        cyc          = 0;
        recv_calm    = 1'b0;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 300 == 0)
                recv_calm = ($urandom_range(0, 3) == 0);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!recv_calm)
                    stall = pick_gap();
            end
        end
    end

    task automatic compare_field(input string fname, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result item with none pending, value %h index %0d count %0d st %0d",
                         $time, rsp_ch.value_out, rsp_ch.index_out, rsp_ch.count_out,
                         rsp_ch.status);
            end
            else
            begin
                seen_want = pending_results.pop_front();
                // value_out is signed: compare its raw bits, not a sign-extended copy
                compare_field("value_out", seen_want.value, $unsigned(rsp_ch.value_out));
                compare_field("index_out", seen_want.index, rsp_ch.index_out);
                compare_field("count_out", seen_want.count, rsp_ch.count_out);
                compare_field("status", seen_want.status, rsp_ch.status);
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_MAX)
        begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_MAX);
            $display("DONE: errors detected");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // main sequence
    initial
    begin
        result_t given;
        err_count          = 0;
        items_sent         = 0;
        idle_cycles        = 0;
        send_calm          = 1'b0;
        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.opcode      = '0;
        cmd_ch.entry_index = '0;
        cmd_ch.amount      = '0;
        entry_cnt          = 0;
        foreach (node_sum[j])
            node_sum[j] = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_plan[i])
        begin
            given = '{dir_plan[i].e_val, dir_plan[i].e_idx, dir_plan[i].e_cnt,
                      dir_plan[i].e_st};
            send_item(dir_plan[i].op, dir_plan[i].idx, dir_plan[i].amt,
                      dir_plan[i].typed, given);
        end

        run_mixed(40);
        fill_to_full();
        run_mixed(15);

        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
